>>> sv/phong_lighting_unit_assert.svh
// Assertion macros for the phong lighting unit RTL.
// Expects clk and rst_n in scope at the point of use.
`ifndef PHONG_LIGHTING_UNIT_ASSERT_SVH
`define PHONG_LIGHTING_UNIT_ASSERT_SVH

// same-cycle implication
`define PLU_ASSERT_IMP(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
    else $error(msg);

// next-cycle implication
`define PLU_ASSERT_NXT(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
    else $error(msg);

`endif

>>> sv/plu_pkg.sv
// Package for the phong lighting unit: widths, latencies, record types.
// No dependencies; imported by every RTL module of the block.
package plu_pkg;

  localparam int SPEC_EXPONENT = 10;

  localparam int FW     = 16;           // one field
  localparam int IN_W   = 9 * FW;       // input tdata
  localparam int OUT_W  = 3 * FW;       // output tdata
  localparam int CFG_AW = 3;

  // normalizer widths
  localparam int MAGW  = 21;            // component magnitude
  localparam int CW    = MAGW + 1;      // signed component
  localparam int SSW   = 2 * MAGW + 2;  // sum of squares
  localparam int ROOTW = SSW / 2;       // square root
  localparam int QW    = 15;            // unit quotient magnitude
  localparam int DRW   = ROOTW + 1;     // divider remainder
  localparam int NORM_LAT = 2 + ROOTW + QW + 1;

  // cosine and power
  localparam int VRW = 29;
  localparam logic [VRW-1:0] ONE_Q28 = VRW'(1) << 28;

  localparam int BACK_LAT = 6 + NORM_LAT + SPEC_EXPONENT;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;

  typedef enum logic [CFG_AW-1:0] {
    REG_AMB_I  = 3'd0,
    REG_BRIGHT = 3'd1,
    REG_AMB_K  = 3'd2,
    REG_DIFF_K = 3'd3,
    REG_SPEC_K = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [FW-1:0] amb_i;
    logic [FW-1:0] bright;
    logic [FW-1:0] amb_k;
    logic [FW-1:0] diff_k;
    logic [FW-1:0] spec_k;
  } cfg_t;

  // classified item passed from front to back
  typedef struct packed {
    logic [2:0][FW-1:0] l;
    logic [2:0][FW-1:0] n;
    logic [2:0][FW-1:0] d;
    logic               pos;   // n.l > 0
    logic [31:0]        nl;    // n.l when positive
  } rec_t;

endpackage

>>> sv/plu_front.sv
// Front end: accepts items, forms n.l and classifies facing / not facing.
// Depends on plu_pkg; feeds plu_fifo.
module plu_front import plu_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [IN_W-1:0] in_tdata,
  output logic            push,
  output rec_t            rec,
  input  logic            full
);

  logic                f1_v_r, f2_v_r;
  logic [IN_W-1:0]     f1_data_r;
  logic signed [31:0]  f1_prod_r [3];
  logic signed [31:0]  prod_nxt  [3];
  logic signed [33:0]  nl;
  logic                ld1, ld2;
  rec_t                rec_r, rec_nxt;

  assign push      = f2_v_r && !full;
  assign ld2       = !f2_v_r || push;
  assign ld1       = !f1_v_r || ld2;
  assign in_tready = ld1;
  assign rec       = rec_r;

  // component products
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod_nxt[i] = $signed(in_tdata[FW*i +: FW]) * $signed(in_tdata[3*FW + FW*i +: FW]);
    end
  end

  // dot product and record
  always_comb begin
    nl = 34'(f1_prod_r[0]) + 34'(f1_prod_r[1]) + 34'(f1_prod_r[2]);
    rec_nxt.l   = f1_data_r[3*FW-1:0];
    rec_nxt.n   = f1_data_r[6*FW-1:3*FW];
    rec_nxt.d   = f1_data_r[9*FW-1:6*FW];
    rec_nxt.pos = !nl[33] && (nl != '0);
    rec_nxt.nl  = nl[31:0];
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
      f2_v_r <= 1'b0;
    end else begin
      if (ld1) f1_v_r <= in_tvalid;
      if (ld2) f2_v_r <= f1_v_r;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (ld1 && in_tvalid) begin
      f1_data_r <= in_tdata;
      for (int i = 0; i < 3; i++) f1_prod_r[i] <= prod_nxt[i];
    end
    if (ld2 && f1_v_r) rec_r <= rec_nxt;
  end

endmodule

>>> sv/plu_fifo.sv
// Short register queue between front and back ends.
// Depends on plu_pkg and the assertion macro header.
`include "phong_lighting_unit_assert.svh"
module plu_fifo import plu_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  rec_t wr_rec,
  input  logic pop,
  output rec_t rd_rec,
  output logic full,
  output logic empty
);

  localparam int CNT_W = FIFO_AW + 1;

  rec_t               q_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wp_r, rp_r;
  logic [CNT_W-1:0]   cnt_r;

  assign full   = (cnt_r == CNT_W'(FIFO_DEPTH));
  assign empty  = (cnt_r == '0);
  assign rd_rec = q_r[rp_r];

  // pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= wr_rec;
  end

  `PLU_ASSERT_IMP(a_cnt_range, 1'b1, cnt_r <= CNT_W'(FIFO_DEPTH), "queue count past depth")
  `PLU_ASSERT_IMP(a_no_underrun, pop, !empty, "pop from empty queue")
  `PLU_ASSERT_NXT(a_cnt_inc, push && !pop, cnt_r == $past(cnt_r) + 1'b1, "count not bumped")
  `PLU_ASSERT_NXT(a_cnt_dec, pop && !push, cnt_r == $past(cnt_r) - 1'b1, "count not dropped")

endmodule

>>> sv/plu_norm.sv
// Pipelined vector normalizer: squares, bit-by-bit square root, divide.
// Depends on plu_pkg; instantiated twice by plu_back.
module plu_norm import plu_pkg::*; (
  input  logic                clk,
  input  logic                en,
  input  logic [2:0][CW-1:0]  c,
  output logic [2:0][FW-1:0]  u
);

  localparam int SQW = 2 * MAGW;
  localparam int TW  = SSW + 2;

  logic [2:0][MAGW-1:0] mag_nxt, s0_mag_r;
  logic [2:0][SQW-1:0]  s0_sq_r;
  logic [2:0]           s0_sg_r;

  logic [SSW-1:0]        srem_r  [ROOTW+1];
  logic [ROOTW-1:0]      sroot_r [ROOTW+1];
  logic [2:0][MAGW-1:0]  cm_r    [ROOTW+1];
  logic [2:0]            cs_r    [ROOTW+1];

  logic [2:0][DRW-1:0]   drem_r [QW];
  logic [2:0][QW-1:0]    dq_r   [QW];
  logic [ROOTW-1:0]      dm_r   [QW];
  logic [2:0]            dsg_r  [QW];

  logic [2:0][FW-1:0]    u_r;

  assign u = u_r;

  // magnitudes
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_nxt[i] = c[i][CW-1] ? MAGW'(-$signed(c[i])) : MAGW'(c[i]);
    end
  end

  // squares, then their sum
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s0_mag_r[i] <= mag_nxt[i];
        s0_sq_r[i]  <= mag_nxt[i] * mag_nxt[i];
        s0_sg_r[i]  <= c[i][CW-1];
      end
      srem_r[0]  <= SSW'(s0_sq_r[0]) + SSW'(s0_sq_r[1]) + SSW'(s0_sq_r[2]);
      sroot_r[0] <= '0;
      cm_r[0]    <= s0_mag_r;
      cs_r[0]    <= s0_sg_r;
    end
  end

  // square root, one result bit per stage
  for (genvar j = 0; j < ROOTW; j++) begin : g_sqrt
    localparam int K = ROOTW - 1 - j;
    logic [TW-1:0] trial;
    logic          ge;
    assign trial = (TW'(sroot_r[j]) << (K + 1)) + (TW'(1) << (2 * K));
    assign ge    = {2'b00, srem_r[j]} >= trial;
    always_ff @(posedge clk) begin
      if (en) begin
        srem_r[j+1]  <= ge ? SSW'({2'b00, srem_r[j]} - trial) : srem_r[j];
        sroot_r[j+1] <= ge ? (sroot_r[j] + (ROOTW'(1) << K)) : sroot_r[j];
        cm_r[j+1]    <= cm_r[j];
        cs_r[j+1]    <= cs_r[j];
      end
    end
  end

  // restoring divide of magnitude * 2^14 by the root
  for (genvar j = 0; j < QW; j++) begin : g_div
    logic [2:0][DRW-1:0] rsrc, rout;
    logic [2:0][QW-1:0]  qsrc;
    logic [ROOTW-1:0]    msrc;
    logic [2:0]          ssrc, ge;
    if (j == 0) begin : g_first
      always_comb begin
        for (int i = 0; i < 3; i++) rsrc[i] = DRW'(cm_r[ROOTW][i]);
        qsrc = '0;
        msrc = sroot_r[ROOTW];
        ssrc = cs_r[ROOTW];
      end
    end else begin : g_next
      always_comb begin
        for (int i = 0; i < 3; i++) rsrc[i] = {drem_r[j-1][i][DRW-2:0], 1'b0};
        qsrc = dq_r[j-1];
        msrc = dm_r[j-1];
        ssrc = dsg_r[j-1];
      end
    end
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        ge[i]   = rsrc[i] >= DRW'(msrc);
        rout[i] = ge[i] ? (rsrc[i] - DRW'(msrc)) : rsrc[i];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          drem_r[j][i] <= rout[i];
          dq_r[j][i]   <= {qsrc[i][QW-2:0], ge[i]};
        end
        dm_r[j]  <= msrc;
        dsg_r[j] <= ssrc;
      end
    end
  end

  // sign and zero-length vector
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (dm_r[QW-1] == '0)  u_r[i] <= '0;
        else if (dsg_r[QW-1][i]) u_r[i] <= -FW'(dq_r[QW-1][i]);
        else                     u_r[i] <= FW'(dq_r[QW-1][i]);
      end
    end
  end

endmodule

>>> sv/plu_back.sv
// Back end: reflection vector, normalization, cosine power, output terms.
// Depends on plu_pkg and plu_norm; pops classified items from plu_fifo.
module plu_back import plu_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg,
  input  rec_t             rec,
  input  logic             empty,
  output logic             pop,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata
);

  localparam int SIDE_LO = 3;
  localparam int SIDE_HI = 5 + NORM_LAT + SPEC_EXPONENT;

  typedef struct packed {
    logic [FW-1:0] amb;
    logic [FW-1:0] diff;
    logic [31:0]   sb;
    logic          pos;
  } side_t;

  logic en;
  logic vld_r [1:BACK_LAT];

  // stage 1
  logic [47:0]        s1_p_r    [3];
  logic [2:0]         s1_nneg_r;
  logic [FW-1:0]      s1_l_r    [3];
  logic signed [16:0] s1_vd_r   [3];
  logic [31:0]        s1_nl_r, s1_kb_r, s1_sb_r;
  logic [FW-1:0]      s1_amb_r;
  logic               s1_pos_r;
  logic [FW-1:0]      absn      [3];

  // stage 2
  logic [2:0][CW-1:0] s2_w_r, s2_vd_r, w_nxt;
  logic [63:0]        s2_dprod_r;
  logic [FW-1:0]      s2_amb_r;
  logic [31:0]        s2_sb_r;
  logic               s2_pos_r;
  logic [FW-1:0]      diff_nxt;

  side_t side_r [SIDE_LO:SIDE_HI];

  // after normalization
  logic [2:0][FW-1:0] ur, uv;
  logic signed [31:0] vp_r [3];
  logic signed [33:0] vs;
  logic [VRW-1:0]     vr_nxt, vr_e_r;
  logic [VRW-1:0]     pw_r [1:SPEC_EXPONENT];
  logic [VRW-1:0]     pv_r [1:SPEC_EXPONENT];
  logic [VRW+31:0]    sprod_r;
  logic [FW-1:0]      spec_nxt;
  logic [OUT_W-1:0]   out_r;

  assign out_tvalid = vld_r[BACK_LAT];
  assign en         = !vld_r[BACK_LAT] || out_tready;
  assign pop        = en && !empty;
  assign out_tdata  = out_r;

  // valid line
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 1; k <= BACK_LAT; k++) vld_r[k] <= 1'b0;
    end else if (en) begin
      vld_r[1] <= pop;
      for (int k = 2; k <= BACK_LAT; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  // stage 1: n.l times |n|, coefficient products
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      absn[i] = rec.n[i][FW-1] ? (~rec.n[i] + 1'b1) : rec.n[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s1_p_r[i]    <= 48'(rec.nl) * 48'(absn[i]);
        s1_nneg_r[i] <= rec.n[i][FW-1];
        s1_l_r[i]    <= rec.l[i];
        s1_vd_r[i]   <= -$signed({rec.d[i][FW-1], rec.d[i]});
      end
      s1_nl_r  <= rec.nl;
      s1_pos_r <= rec.pos;
      s1_kb_r  <= 32'(cfg.diff_k) * 32'(cfg.bright);
      s1_sb_r  <= 32'(cfg.spec_k) * 32'(cfg.bright);
      s1_amb_r <= FW'((32'(cfg.amb_k) * 32'(cfg.amb_i)) >> 16);
    end
  end

  // stage 2: unnormalized reflection vector, diffuse product
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic signed [CW-1:0] qs, ls;
      qs = $signed({1'b0, s1_p_r[i][47:27]});
      ls = CW'($signed(s1_l_r[i]));
      w_nxt[i] = (s1_nneg_r[i] ? -qs : qs) - ls;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_w_r <= w_nxt;
      for (int i = 0; i < 3; i++) s2_vd_r[i] <= CW'(s1_vd_r[i]);
      s2_dprod_r <= 64'(s1_nl_r) * 64'(s1_kb_r);
      s2_amb_r   <= s1_amb_r;
      s2_sb_r    <= s1_sb_r;
      s2_pos_r   <= s1_pos_r;
    end
  end

  assign diff_nxt = !s2_pos_r ? '0 :
                    (|s2_dprod_r[63:60]) ? '1 : s2_dprod_r[59:44];

  // side data runs beside the normalizers
  always_ff @(posedge clk) begin
    if (en) begin
      side_r[SIDE_LO] <= '{amb: s2_amb_r, diff: diff_nxt, sb: s2_sb_r, pos: s2_pos_r};
      for (int k = SIDE_LO + 1; k <= SIDE_HI; k++) side_r[k] <= side_r[k-1];
    end
  end

  plu_norm u_norm_r (.clk(clk), .en(en), .c(s2_w_r),  .u(ur));
  plu_norm u_norm_v (.clk(clk), .en(en), .c(s2_vd_r), .u(uv));

  // v.r products, then clamped sum
  always_comb begin
    vs = 34'(vp_r[0]) + 34'(vp_r[1]) + 34'(vp_r[2]);
    if (vs[33])                            vr_nxt = '0;
    else if (vs > $signed({5'b0, ONE_Q28})) vr_nxt = ONE_Q28;
    else                                   vr_nxt = vs[VRW-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) vp_r[i] <= $signed(uv[i]) * $signed(ur[i]);
      vr_e_r <= vr_nxt;
    end
  end

  // power, one multiply per stage
  for (genvar k = 1; k <= SPEC_EXPONENT; k++) begin : g_pow
    logic [VRW-1:0]   psrc, vsrc;
    logic [2*VRW-1:0] prod;
    if (k == 1) begin : g_first
      assign psrc = ONE_Q28;
      assign vsrc = vr_e_r;
    end else begin : g_next
      assign psrc = pw_r[k-1];
      assign vsrc = pv_r[k-1];
    end
    assign prod = (2*VRW)'(psrc) * (2*VRW)'(vsrc);
    always_ff @(posedge clk) begin
      if (en) begin
        pw_r[k] <= prod[28 +: VRW];
        pv_r[k] <= vsrc;
      end
    end
  end

  // specular product and output register
  always_ff @(posedge clk) begin
    if (en) sprod_r <= (VRW+32)'(pw_r[SPEC_EXPONENT]) * (VRW+32)'(side_r[SIDE_HI-1].sb);
  end

  assign spec_nxt = !side_r[SIDE_HI].pos ? '0 :
                    sprod_r[VRW+31] ? '1 : sprod_r[59:44];

  always_ff @(posedge clk) begin
    if (en) out_r <= {spec_nxt, side_r[SIDE_HI].diff, side_r[SIDE_HI].amb};
  end

endmodule

>>> sv/phong_lighting_unit.sv
// Phong lighting unit, top level: configuration registers and channel wiring.
// Depends on plu_pkg, plu_front, plu_fifo, plu_back.
//
// Takes one ray hit per clock cycle and gives one result per cycle at full
// rate while the output is not stalled; every stage is pipelined, including
// the fully unrolled square-root (22 stages) and divider (15 stages) in each
// normalizer. An item passes the front end, the four-entry queue and the
// back end (2 setup stages, 40 normalizer stages, 2 cosine stages, 10 power
// stages, 2 output stages). Both sides may stall independently. Configuration
// registers must be written by the user only while no item is in flight; the
// block itself does not enforce this. They take effect on the next item.
module phong_lighting_unit import plu_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  // light_x, light_y, light_z, normal_x, normal_y, normal_z, dir_x, dir_y, dir_z
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_W-1:0]   in_tdata,
  // ambient_out, diffuse_out, specular_out
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_W-1:0]  out_tdata,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [FW-1:0]     cfg_wdata
);

  cfg_t cfg_r;
  rec_t f_rec, q_rec;
  logic push, pop, full, empty;

  // register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_addr))
        REG_AMB_I:  cfg_r.amb_i  <= cfg_wdata;
        REG_BRIGHT: cfg_r.bright <= cfg_wdata;
        REG_AMB_K:  cfg_r.amb_k  <= cfg_wdata;
        REG_DIFF_K: cfg_r.diff_k <= cfg_wdata;
        REG_SPEC_K: cfg_r.spec_k <= cfg_wdata;
        default: ;
      endcase
    end
  end

  plu_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .push(push), .rec(f_rec), .full(full)
  );

  plu_fifo u_fifo (
    .clk(clk), .rst_n(rst_n),
    .push(push), .wr_rec(f_rec), .pop(pop), .rd_rec(q_rec),
    .full(full), .empty(empty)
  );

  plu_back u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r),
    .rec(q_rec), .empty(empty), .pop(pop),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

endmodule

>>> sim/tb_phong_lighting_unit.sv
// Testbench for phong_lighting_unit: random and directed ray hits checked
// against a bit-accurate fixed-point Phong predictor. Depends on plu_pkg and phong_lighting_unit.
`timescale 1ns / 100ps

module tb_phong_lighting_unit import plu_pkg::*; ();

  localparam int LATENCY   = 80;
  localparam int WDOG_LIM  = 20000;
  localparam int HOLD_LEN  = 400;

  typedef struct packed {
    logic signed [FW-1:0] lx, ly, lz, nx, ny, nz, dx, dy, dz;
  } hit_t;

  typedef struct packed {
    logic [FW-1:0] amb, dif, spec;
  } shade_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_addr = '0;
  logic [FW-1:0] cfg_wdata = '0;
  logic in_acc = 1'b0;

  phong_lighting_unit dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor copy of the light and material registers
  logic [FW-1:0] lit_regs [5];
  hit_t   pending_hits [$];
  shade_t expected_shades [$];
  int     errors = 0;
  int     send_idle_pct = 0;
  int     recv_idle_pct = 0;
  int     hold_cycles = 0;
  int     quiet_cycles = 0;

  function automatic longint isqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  // scale a Q.14 vector to unit length; zero length gives zero
  function automatic void unit_vec(input longint c[3], output longint u[3]);
    longint unsigned ss;
    longint m;
    ss = 0;
    for (int i = 0; i < 3; i++) ss += longint'(c[i] * c[i]);
    m = isqrt(ss);
    for (int i = 0; i < 3; i++) u[i] = (m == 0) ? 0 : (c[i] * 16384) / m;
  endfunction

  function automatic logic [FW-1:0] sat(longint unsigned v);
    return (v > 65535) ? 16'hFFFF : v[FW-1:0];
  endfunction

  function automatic shade_t shade_hit(hit_t h);
    longint l[3], n[3], vd[3], w[3], ur[3], uv[3];
    longint nl, vr;
    longint unsigned amb, dif, spec, p;
    shade_t s;
    l = '{h.lx, h.ly, h.lz};
    n = '{h.nx, h.ny, h.nz};
    vd = '{-longint'(h.dx), -longint'(h.dy), -longint'(h.dz)};
    amb = (longint'(lit_regs[REG_AMB_K]) * lit_regs[REG_AMB_I]) >> 16;
    nl = l[0] * n[0] + l[1] * n[1] + l[2] * n[2];
    dif = 0;
    spec = 0;
    if (nl > 0) begin
      dif = (longint'(nl) * lit_regs[REG_DIFF_K] * lit_regs[REG_BRIGHT]) >> 44;
      for (int i = 0; i < 3; i++) w[i] = (2 * nl * n[i]) / (64'sd1 <<< 28) - l[i];
      unit_vec(w, ur);
      unit_vec(vd, uv);
      vr = uv[0] * ur[0] + uv[1] * ur[1] + uv[2] * ur[2];
      if (vr < 0) vr = 0;
      if (vr > (64'sd1 <<< 28)) vr = 64'sd1 <<< 28;
      p = 64'd1 << 28;
      for (int i = 0; i < SPEC_EXPONENT; i++) p = (p * longint'(vr)) >> 28;
      spec = (p * lit_regs[REG_SPEC_K] * lit_regs[REG_BRIGHT]) >> 44;
    end
    s.amb = sat(amb);
    s.dif = sat(dif);
    s.spec = sat(spec);
    return s;
  endfunction

  // driver: offers pending hits, predicts on acceptance
  always @(negedge clk) begin
    if (in_acc) begin
      expected_shades.push_back(shade_hit(pending_hits.pop_front()));
    end
    if (rst_n && pending_hits.size() > 0 &&
        (in_tvalid && !in_acc || $urandom_range(99) >= send_idle_pct)) begin
      in_tvalid <= 1'b1;
      in_tdata  <= {pending_hits[0].dz, pending_hits[0].dy, pending_hits[0].dx,
                    pending_hits[0].nz, pending_hits[0].ny, pending_hits[0].nx,
                    pending_hits[0].lz, pending_hits[0].ly, pending_hits[0].lx};
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // receiver: random backpressure, plus a long hold when requested
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // monitor: compare each result with the oldest expectation
  always @(posedge clk) begin
    shade_t got, want;
    in_acc <= in_tvalid && in_tready;
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{amb: out_tdata[15:0], dif: out_tdata[31:16], spec: out_tdata[47:32]};
      if (expected_shades.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_tdata);
        errors++;
      end else begin
        want = expected_shades.pop_front();
        if (got.amb != want.amb) begin
          $display("%0t: ambient exp %0d got %0d", $time, want.amb, got.amb);
          errors++;
        end
        if (got.dif != want.dif) begin
          $display("%0t: diffuse exp %0d got %0d", $time, want.dif, got.dif);
          errors++;
        end
        if (got.spec != want.spec) begin
          $display("%0t: specular exp %0d got %0d", $time, want.spec, got.spec);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (quiet_cycles >= WDOG_LIM) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [FW-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    lit_regs[idx] = val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain_all();
    while (pending_hits.size() > 0 || expected_shades.size() > 0 || in_tvalid)
      @(negedge clk);
    repeat (LATENCY) @(negedge clk);
  endtask

  task automatic load_regs(int mode);
    for (int r = 0; r < 5; r++) begin
      case (mode)
        0: write_reg(reg_idx_t'(r), 16'hFFFF);
        1: write_reg(reg_idx_t'(r), 16'h0000);
        default: write_reg(reg_idx_t'(r), 16'($urandom));
      endcase
    end
  endtask

  function automatic logic [FW-1:0] rand_comp();
    case ($urandom_range(5))
      0: return 16'($urandom);
      1: return 16'h8000;
      2: return 16'h7FFF;
      3: return 16'd0;
      default: return 16'($signed($urandom_range(32768)) - 16384);
    endcase
  endfunction

  // mostly unit-ish vectors; some raw noise
  function automatic hit_t rand_hit();
    hit_t h;
    h = IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom});
    if ($urandom_range(3) != 0) begin
      h.lx = rand_comp(); h.ly = rand_comp(); h.lz = rand_comp();
      h.nx = rand_comp(); h.ny = rand_comp(); h.nz = rand_comp();
      h.dx = rand_comp(); h.dy = rand_comp(); h.dz = rand_comp();
      // reflect-friendly: ray points against mirrored light
      if ($urandom_range(1)) begin
        h.nx = '0; h.ny = '0; h.nz = 16'sd16384; h.lz = 16'sd14000;
        h.dx = h.lx; h.dy = h.ly; h.dz = -16'sd14000;
      end
    end
    return h;
  endfunction

  initial begin
    hit_t h;
    foreach (lit_regs[i]) lit_regs[i] = '0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // directed: extremes, facing away, zero vectors, perfect mirror
    load_regs(0);
    h = '{lx: 0, ly: 0, lz: 16384, nx: 0, ny: 0, nz: 16384, dx: 0, dy: 0, dz: -16384};
    pending_hits.push_back(h);
    h.dz = 16'sd16384; pending_hits.push_back(h);
    h.lz = -16'sd16384; pending_hits.push_back(h);
    h = '{default: 0}; pending_hits.push_back(h);
    h.lz = 16'sd16384; h.nz = 16'sd16384; pending_hits.push_back(h);
    h = '{default: 16'h8000}; pending_hits.push_back(h);
    h = '{default: 16'h7FFF}; pending_hits.push_back(h);
    h = '{lx: 11585, ly: 0, lz: 11585, nx: 0, ny: 0, nz: 16384,
          dx: 11585, dy: 0, dz: -11585};
    pending_hits.push_back(h);
    h.dx = -16'sd11585; pending_hits.push_back(h);
    for (int i = 0; i < 8; i++) pending_hits.push_back(rand_hit());
    drain_all();
    load_regs(1);
    for (int i = 0; i < 8; i++) pending_hits.push_back(rand_hit());
    drain_all();

    // random phases with changing idle profile
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 6 : (ph == 1) ? 73 : 0;
      recv_idle_pct = (ph == 0) ? 73 : (ph == 1) ? 6 : 0;
      load_regs(ph == 2 ? 0 : 2);
      if (ph == 2) hold_cycles = HOLD_LEN;
      for (int i = 0; i < 230; i++) pending_hits.push_back(rand_hit());
      drain_all();
    end

    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+sv
sv/plu_pkg.sv
sv/plu_front.sv
sv/plu_fifo.sv
sv/plu_norm.sv
sv/plu_back.sv
sv/phong_lighting_unit.sv
sim/tb_phong_lighting_unit.sv
